[rtl/core/nand_page_read_sequencer_top_assert.svh]
// Assertion macros for the NAND page read sequencer (expect clk and rst in scope).
`ifndef NAND_PAGE_READ_SEQUENCER_TOP_ASSERT_SVH
`define NAND_PAGE_READ_SEQUENCER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset
`define NPRS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("nprs assertion failed");
// Next-cycle implication, checked outside reset
`define NPRS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("nprs assertion failed");
`else
`define NPRS_ASSERT_NOW(label, pre, post)
`define NPRS_ASSERT_NEXT(label, pre, post)
`endif
`endif

[rtl/core/nprs_pkg.sv]
// Types and constants shared by the NAND page read sequencer.
`default_nettype none
package nprs_pkg;

  // Device geometry
  localparam int unsigned PAGE_BYTES      = 2048;
  localparam int unsigned SPARE_BYTES     = 64;
  localparam int unsigned PAGES_PER_BLOCK = 64;
  localparam int unsigned TOTAL_BLOCKS    = 2048;

  // Page plus spare, 13 bits wide to compare with a zero-extended 12-bit column
  localparam logic [12:0] SPAN = 13'(PAGE_BYTES + SPARE_BYTES);

  // NAND read commands
  localparam logic [7:0] CMD_READ_SETUP   = 8'h00;
  localparam logic [7:0] CMD_READ_CONFIRM = 8'h30;

  // Request opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_READY = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  // Results per read sequence: chip select, cmd, five address bytes, cmd
  localparam int unsigned SEQ_LEN = 8;
  localparam int unsigned IDX_W   = $clog2(SEQ_LEN);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_DATA = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    K_CMD  = 3'd0,
    K_ADDR = 3'd1,
    K_DATA = 3'd2,
    K_REJ  = 3'd3,
    K_CS   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    BT_NONE = 2'd0,
    BT_REJ  = 2'd1,
    BT_SEQ  = 2'd2,
    BT_DATA = 2'd3
  } burst_t;

  // One burst of results handed to the emitter
  typedef struct packed {
    burst_t      burst;
    logic [11:0] blk;
    logic [6:0]  pg;
    logic [11:0] off;
    logic [7:0]  data;
    logic        fin;
  } desc_t;

  // Decoder verdict for one request
  typedef struct packed {
    desc_t       desc;
    logic        state_we;
    phase_t      phase;
    logic [11:0] bytes_left;
  } dec_t;

endpackage
`default_nettype wire

[rtl/core/nprs_in_if.sv]
// Input request channel of the NAND page read sequencer.
`default_nettype none
interface nprs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [11:0] block_number;
  logic [6:0]  page_number;
  logic [11:0] column_offset;
  logic [11:0] byte_count;
  logic        ready_flag;
  logic [7:0]  flash_byte;

  modport source (
    output valid, op, block_number, page_number, column_offset, byte_count,
           ready_flag, flash_byte,
    input  ready
  );
  modport sink (
    input  valid, op, block_number, page_number, column_offset, byte_count,
           ready_flag, flash_byte,
    output ready
  );
endinterface
`default_nettype wire

[rtl/core/nprs_out_if.sv]
// Result channel of the NAND page read sequencer.
`default_nettype none
interface nprs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, kind, value, last, input ready);
  modport sink (input valid, kind, value, last, output ready);
endinterface
`default_nettype wire

[rtl/core/nand_page_read_sequencer_top.sv]
// Top level of the NAND page read sequencer.
// Requests are taken into an input register, decoded combinationally against
// the phase and remaining length, and handed as a burst to the emitter, which
// drives the registered result port. Ready samples and ignored requests are
// taken one per cycle; data bytes one per cycle while the emitter is free, and
// a data byte gives one result. A read yields eight results (chip select,
// 0x00, five address bytes, 0x30) and a rejection one; the result port moves
// one result per cycle while ready is high, so a read holds the input until
// its last result is registered, via the input, burst and result registers.
`default_nettype none
`include "nand_page_read_sequencer_top_assert.svh"
module nand_page_read_sequencer_top (
  input  wire logic  clk,
  input  wire logic  rst,
  nprs_in_if.sink    item,
  nprs_out_if.source result
);

  logic             s1_valid;
  logic [1:0]       s1_op;
  logic [11:0]      s1_blk;
  logic [6:0]       s1_pg;
  logic [11:0]      s1_off;
  logic [11:0]      s1_len;
  logic             s1_rdy;
  logic [7:0]       s1_byte;
  nprs_pkg::phase_t phase;
  logic [11:0]      bytes_left;
  nprs_pkg::dec_t   dec;
  logic             free_next;
  logic             s1_take;
  logic             push;

  // Input register advance
  assign s1_take    = s1_valid && (dec.desc.burst == nprs_pkg::BT_NONE || free_next);
  assign push       = s1_take && (dec.desc.burst != nprs_pkg::BT_NONE);
  assign item.ready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready) begin
      s1_op   <= item.op;
      s1_blk  <= item.block_number;
      s1_pg   <= item.page_number;
      s1_off  <= item.column_offset;
      s1_len  <= item.byte_count;
      s1_rdy  <= item.ready_flag;
      s1_byte <= item.flash_byte;
    end
  end

  nprs_decode u_decode (
    .op            (s1_op),
    .block_number  (s1_blk),
    .page_number   (s1_pg),
    .column_offset (s1_off),
    .byte_count    (s1_len),
    .ready_flag    (s1_rdy),
    .flash_byte    (s1_byte),
    .phase         (phase),
    .bytes_left    (bytes_left),
    .dec           (dec)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= nprs_pkg::PH_IDLE;
      bytes_left <= 12'd0;
    end else if (s1_take && dec.state_we) begin
      phase      <= dec.phase;
      bytes_left <= dec.bytes_left;
    end
  end

  nprs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .desc      (dec.desc),
    .free_next (free_next),
    .result    (result)
  );

  `NPRS_ASSERT_NOW(a_data_has_len, phase == nprs_pkg::PH_DATA, bytes_left != 12'd0)
  `NPRS_ASSERT_NEXT(a_s1_holds, s1_valid && !s1_take, s1_valid && $stable(s1_op))

endmodule
`default_nettype wire

[rtl/core/nprs_decode.sv]
// Request decoder: range checks, phase transitions and burst selection.
`default_nettype none
module nprs_decode (
  input  wire logic [1:0]      op,
  input  wire logic [11:0]     block_number,
  input  wire logic [6:0]      page_number,
  input  wire logic [11:0]     column_offset,
  input  wire logic [11:0]     byte_count,
  input  wire logic            ready_flag,
  input  wire logic [7:0]      flash_byte,
  input  wire nprs_pkg::phase_t phase,
  input  wire logic [11:0]     bytes_left,
  output nprs_pkg::dec_t       dec
);

  logic        bad;
  logic [12:0] room;
  logic [11:0] left_dec;

  // Idle, block and page checks; offset in page plus spare, end not past it
  assign room     = nprs_pkg::SPAN - {1'b0, column_offset};
  assign left_dec = bytes_left - 12'd1;
  assign bad = (phase != nprs_pkg::PH_IDLE)
            || ({1'b0, block_number} >= 13'(nprs_pkg::TOTAL_BLOCKS))
            || (page_number >= 7'(nprs_pkg::PAGES_PER_BLOCK))
            || ({1'b0, column_offset} >= nprs_pkg::SPAN)
            || ({1'b0, byte_count} > room);

  always_comb begin
    dec                 = '0;
    dec.desc.burst      = nprs_pkg::BT_NONE;
    dec.desc.blk        = block_number;
    dec.desc.pg         = page_number;
    dec.desc.off        = column_offset;
    dec.desc.data       = flash_byte;
    dec.desc.fin        = (bytes_left == 12'd1);
    dec.state_we        = 1'b0;
    dec.phase           = phase;
    dec.bytes_left      = bytes_left;
    unique case (op)
      nprs_pkg::OP_READ: begin
        if (bad) begin
          dec.desc.burst = nprs_pkg::BT_REJ;
        end else begin
          dec.desc.burst = nprs_pkg::BT_SEQ;
          dec.state_we   = 1'b1;
          dec.phase      = nprs_pkg::PH_WAIT;
          dec.bytes_left = byte_count;
        end
      end
      nprs_pkg::OP_READY: begin
        if (phase == nprs_pkg::PH_WAIT && ready_flag) begin
          dec.state_we = 1'b1;
          dec.phase    = (bytes_left != 12'd0) ? nprs_pkg::PH_DATA : nprs_pkg::PH_IDLE;
        end
      end
      nprs_pkg::OP_DATA: begin
        if (phase == nprs_pkg::PH_DATA && bytes_left != 12'd0) begin
          dec.desc.burst = nprs_pkg::BT_DATA;
          dec.state_we   = 1'b1;
          dec.bytes_left = left_dec;
          dec.phase      = (left_dec == 12'd0) ? nprs_pkg::PH_IDLE : nprs_pkg::PH_DATA;
        end
      end
      default: begin
        // unused opcode: no effect
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/nprs_emit.sv]
// Burst emitter: serializes one burst into the registered result channel.
`default_nettype none
`include "nand_page_read_sequencer_top_assert.svh"
module nprs_emit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire nprs_pkg::desc_t desc,
  output logic                 free_next,
  nprs_out_if.source           result
);

  logic                          b_valid;
  nprs_pkg::desc_t               b;
  logic [nprs_pkg::IDX_W-1:0]    idx;
  logic                          b_emit;
  logic                          b_final;
  nprs_pkg::kind_t               e_kind;
  logic [7:0]                    e_value;
  logic                          e_last;

  // Burst register can move one result per cycle into the output register while it is empty or read
  assign b_emit    = b_valid && (!result.valid || result.ready);
  assign b_final   = (b.burst != nprs_pkg::BT_SEQ)
                  || (idx == nprs_pkg::IDX_W'(nprs_pkg::SEQ_LEN - 1));
  assign free_next = !b_valid || (b_emit && b_final);

  // Current element of the burst
  always_comb begin
    e_kind  = nprs_pkg::K_REJ;
    e_value = 8'd0;
    e_last  = 1'b1;
    case (b.burst)
      nprs_pkg::BT_DATA: begin
        e_kind  = nprs_pkg::K_DATA;
        e_value = b.data;
        e_last  = b.fin;
      end
      nprs_pkg::BT_SEQ: begin
        e_last = 1'b0;
        unique case (idx)
          3'd0: e_kind = nprs_pkg::K_CS;
          3'd1: begin
            e_kind  = nprs_pkg::K_CMD;
            e_value = nprs_pkg::CMD_READ_SETUP;
          end
          3'd2: begin
            e_kind  = nprs_pkg::K_ADDR;
            e_value = b.off[7:0];
          end
          3'd3: begin
            e_kind  = nprs_pkg::K_ADDR;
            e_value = {4'd0, b.off[11:8]};
          end
          3'd4: begin
            e_kind  = nprs_pkg::K_ADDR;
            e_value = {1'b0, b.pg} | {b.blk[1:0], 6'd0};
          end
          3'd5: begin
            e_kind  = nprs_pkg::K_ADDR;
            e_value = b.blk[9:2];
          end
          3'd6: begin
            e_kind  = nprs_pkg::K_ADDR;
            e_value = {6'd0, b.blk[11:10]};
          end
          default: begin
            e_kind  = nprs_pkg::K_CMD;
            e_value = nprs_pkg::CMD_READ_CONFIRM;
            e_last  = 1'b1;
          end
        endcase
      end
      default: begin
        // rejection: defaults above
      end
    endcase
  end

  // Burst register and element counter
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      idx     <= '0;
    end else if (push) begin
      b_valid <= 1'b1;
      idx     <= '0;
    end else if (b_emit && b_final) begin
      b_valid <= 1'b0;
    end else if (b_emit) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      b <= desc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (b_emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_emit) begin
      result.kind  <= e_kind;
      result.value <= e_value;
      result.last  <= e_last;
    end
  end

  `NPRS_ASSERT_NOW(a_single_idx, b_valid && b.burst != nprs_pkg::BT_SEQ, idx == '0)
  `NPRS_ASSERT_NEXT(a_push_starts, push, b_valid && idx == '0)

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the NAND page read sequencer: directed table, then random reads.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         IDLE_PCT     = 8;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         LIMIT_CYCLES = 200000;
  localparam int         TARGET_ITEMS = 360;

  // One request on the input channel
  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] blk;
    logic [6:0]  pg;
    logic [11:0] col;
    logic [11:0] count;
    logic        rdy;
    logic [7:0]  data;
  } nand_req_t;

  // One result on the output channel
  typedef struct packed {
    nprs_pkg::kind_t kind;
    logic [7:0]      value;
    logic            last;
  } bus_result_t;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_REJECT,
    CHK_SILENT
  } row_chk_t;

  typedef struct packed {
    nand_req_t req;
    row_chk_t  chk;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nprs_in_if  item_if ();
  nprs_out_if result_if ();

  nand_page_read_sequencer_top uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  // Predictor state
  nprs_pkg::phase_t model_phase;
  logic [11:0]      model_left;
  bus_result_t      step_out [nprs_pkg::SEQ_LEN];
  bus_result_t      expected_bus_results [$];

  dir_row_t directed_rows [24];
  int       errors = 0;
  int       cycle_count = 0;
  bit       steady = 1'b0;
  bit       hold_off_req = 1'b0;
  bit       hold_off_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected results of one request; updates the predicted phase and length
  function automatic int nand_read_predict(input nand_req_t r);
    bit bad;
    int n;
    n = 0;
    case (r.op)
      nprs_pkg::OP_READ: begin
        bad = model_phase != nprs_pkg::PH_IDLE || r.blk >= nprs_pkg::TOTAL_BLOCKS
          || r.pg >= nprs_pkg::PAGES_PER_BLOCK || {1'b0, r.col} >= nprs_pkg::SPAN
          || {1'b0, r.count} > nprs_pkg::SPAN - {1'b0, r.col};
        if (bad) begin
          step_out[0] = '{nprs_pkg::K_REJ, 8'h00, 1'b1};
          n = 1;
        end else begin
          step_out[0] = '{nprs_pkg::K_CS, 8'h00, 1'b0};
          step_out[1] = '{nprs_pkg::K_CMD, nprs_pkg::CMD_READ_SETUP, 1'b0};
          step_out[2] = '{nprs_pkg::K_ADDR, r.col[7:0], 1'b0};
          step_out[3] = '{nprs_pkg::K_ADDR, {4'h0, r.col[11:8]}, 1'b0};
          step_out[4] = '{nprs_pkg::K_ADDR, {1'b0, r.pg} | {r.blk[1:0], 6'h00}, 1'b0};
          step_out[5] = '{nprs_pkg::K_ADDR, r.blk[9:2], 1'b0};
          step_out[6] = '{nprs_pkg::K_ADDR, {6'h00, r.blk[11:10]}, 1'b0};
          step_out[7] = '{nprs_pkg::K_CMD, nprs_pkg::CMD_READ_CONFIRM, 1'b1};
          model_left  = r.count;
          model_phase = nprs_pkg::PH_WAIT;
          n = 8;
        end
      end
      nprs_pkg::OP_READY: begin
        if (model_phase == nprs_pkg::PH_WAIT && r.rdy)
          model_phase = (model_left != 12'd0) ? nprs_pkg::PH_DATA : nprs_pkg::PH_IDLE;
      end
      nprs_pkg::OP_DATA: begin
        if (model_phase == nprs_pkg::PH_DATA && model_left != 12'd0) begin
          step_out[0] = '{nprs_pkg::K_DATA, r.data, model_left == 12'd1};
          model_left  = model_left - 12'd1;
          if (model_left == 12'd0)
            model_phase = nprs_pkg::PH_IDLE;
          n = 1;
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  function automatic dir_row_t row(input logic [1:0] op, input int blk, input int pg,
                                   input int col, input int count, input bit rdy,
                                   input logic [7:0] data, input row_chk_t chk);
    dir_row_t d;
    d.req = '{op, 12'(blk), 7'(pg), 12'(col), 12'(count), rdy, data};
    d.chk = chk;
    return d;
  endfunction

  function automatic nand_req_t rand_req(input logic [1:0] op);
    nand_req_t r;
    r.op    = op;
    r.blk   = 12'($urandom_range(0, 4095));
    r.pg    = 7'($urandom_range(0, 127));
    r.col   = 12'($urandom_range(0, 4095));
    r.count = 12'($urandom_range(0, 4095));
    r.rdy   = 1'($urandom_range(0, 1));
    r.data  = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Offer one request at the falling edge, wait for it to be taken, record expectations
  task automatic drive_req(input nand_req_t r, input row_chk_t chk);
    int n;
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      item_if.valid <= 1'b0;
      @(negedge clk);
    end
    item_if.valid         <= 1'b1;
    item_if.op            <= r.op;
    item_if.block_number  <= r.blk;
    item_if.page_number   <= r.pg;
    item_if.column_offset <= r.col;
    item_if.byte_count    <= r.count;
    item_if.ready_flag    <= r.rdy;
    item_if.flash_byte    <= r.data;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    n = nand_read_predict(r);
    case (chk)
      CHK_MODEL:  for (int i = 0; i < n; i++) expected_bus_results.push_back(step_out[i]);
      CHK_REJECT: expected_bus_results.push_back(bus_result_t'{nprs_pkg::K_REJ, 8'h00, 1'b1});
      default: ;
    endcase
  endtask

  // Requests the block should drop or reject while a transfer is open
  task automatic drive_noise(input bit allow_data);
    nand_req_t r;
    case ($urandom_range(0, allow_data ? 3 : 2))
      0: r = rand_req(nprs_pkg::OP_READ);
      1: r = rand_req(OP_UNUSED);
      2: begin
        r = rand_req(nprs_pkg::OP_READY);
        r.rdy = 1'b0;
      end
      default: r = rand_req(nprs_pkg::OP_DATA);
    endcase
    drive_req(r, CHK_MODEL);
  endtask

  // Stimulus
  initial begin : stimulus
    nand_req_t r;
    int real_items;
    int seq;
    int cap;
    int pick;
    item_if.valid         = 1'b0;
    item_if.op            = nprs_pkg::OP_READ;
    item_if.block_number  = '0;
    item_if.page_number   = '0;
    item_if.column_offset = '0;
    item_if.byte_count    = '0;
    item_if.ready_flag    = 1'b0;
    item_if.flash_byte    = '0;
    result_if.ready       = 1'b0;
    model_phase           = nprs_pkg::PH_IDLE;
    model_left            = '0;
    real_items            = 0;
    seq                   = 0;

    directed_rows[0]  = row(nprs_pkg::OP_READY, 0, 0, 0, 0, 1, 8'h00, CHK_SILENT); // stray ready
    directed_rows[1]  = row(nprs_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'hFF, CHK_SILENT);  // stray byte
    directed_rows[2]  = row(OP_UNUSED, 4095, 127, 4095, 4095, 1, 8'hFF, CHK_SILENT);
    directed_rows[3]  = row(nprs_pkg::OP_READ, 2048, 0, 0, 0, 0, 8'h00,
                            CHK_REJECT);                                      // block range
    directed_rows[4]  = row(nprs_pkg::OP_READ, 4095, 127, 4095, 4095, 1, 8'hFF, CHK_REJECT);
    directed_rows[5]  = row(nprs_pkg::OP_READ, 0, 64, 0, 0, 0, 8'h00,
                            CHK_REJECT);                                      // page = count
    directed_rows[6]  = row(nprs_pkg::OP_READ, 0, 0, 2112, 0, 0, 8'h00,
                            CHK_REJECT);                                      // past spare
    directed_rows[7]  = row(nprs_pkg::OP_READ, 0, 0, 2000, 113, 0, 8'h00,
                            CHK_REJECT);                                      // span over
    directed_rows[8]  = row(nprs_pkg::OP_READ, 2047, 63, 2111, 1, 1, 8'h00, CHK_MODEL);
    directed_rows[9]  = row(nprs_pkg::OP_READ, 0, 0, 0, 0, 0, 8'h00, CHK_REJECT);  // busy
    directed_rows[10] = row(nprs_pkg::OP_READY, 0, 0, 0, 0, 0, 8'h00, CHK_SILENT); // not ready
    directed_rows[11] = row(nprs_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'h5A,
                            CHK_SILENT);                                      // before ready
    directed_rows[12] = row(nprs_pkg::OP_READY, 0, 0, 0, 0, 1, 8'h00, CHK_SILENT);
    directed_rows[13] = row(nprs_pkg::OP_READY, 0, 0, 0, 0, 1, 8'h00,
                            CHK_SILENT);                                      // stray in data
    directed_rows[14] = row(nprs_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'hFF, CHK_MODEL);
    directed_rows[15] = row(nprs_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'h00, CHK_SILENT);  // after end
    directed_rows[16] = row(nprs_pkg::OP_READ, 0, 0, 0, 0, 0, 8'h00, CHK_MODEL);   // zero length
    directed_rows[17] = row(nprs_pkg::OP_READY, 0, 0, 0, 0, 1, 8'h00, CHK_SILENT);
    directed_rows[18] = row(nprs_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'h33, CHK_SILENT);
    directed_rows[19] = row(nprs_pkg::OP_READ, 1365, 42, 2109, 3, 0, 8'h00,
                            CHK_MODEL);                                       // ends at span
    directed_rows[20] = row(nprs_pkg::OP_READY, 0, 0, 0, 0, 1, 8'h00, CHK_SILENT);
    directed_rows[21] = row(nprs_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'h00, CHK_MODEL);
    directed_rows[22] = row(nprs_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'hA5, CHK_MODEL);
    directed_rows[23] = row(nprs_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'h5A, CHK_MODEL);

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) drive_req(directed_rows[i].req, directed_rows[i].chk);

    // Random read sequences, a few malformed, with noise mixed in
    while (real_items < TARGET_ITEMS) begin
      seq++;
      steady = (seq >= 8 && seq < 14);
      if (seq == 4) hold_off_req = 1'b1;
      r = rand_req(nprs_pkg::OP_READ);
      if ($urandom_range(0, 99) < 12) begin
        r.col = 12'($urandom_range(0, nprs_pkg::SPAN - 1));
        case ($urandom_range(0, 3))
          0: r.blk = 12'($urandom_range(nprs_pkg::TOTAL_BLOCKS, 4095));
          1: r.pg = 7'($urandom_range(nprs_pkg::PAGES_PER_BLOCK, 127));
          2: r.col = 12'($urandom_range(nprs_pkg::SPAN, 4095));
          default: r.count = 12'($urandom_range(nprs_pkg::SPAN - r.col + 1, 4095));
        endcase
        drive_req(r, CHK_MODEL);
        real_items++;
      end else begin
        r.blk = 12'($urandom_range(0, nprs_pkg::TOTAL_BLOCKS - 1));
        r.pg  = 7'($urandom_range(0, nprs_pkg::PAGES_PER_BLOCK - 1));
        r.col = 12'($urandom_range(0, nprs_pkg::SPAN - 1));
        pick  = $urandom_range(0, 99);
        cap   = (pick < 70) ? 6 : (pick < 95) ? 40 : 200;
        if (cap > nprs_pkg::SPAN - r.col) cap = nprs_pkg::SPAN - r.col;
        r.count = 12'($urandom_range(0, cap));
        drive_req(r, CHK_MODEL);
        real_items++;
        repeat ($urandom_range(0, 2)) drive_noise(1'b1);
        r = rand_req(nprs_pkg::OP_READY);
        r.rdy = 1'b1;
        drive_req(r, CHK_MODEL);
        real_items++;
        while (model_phase == nprs_pkg::PH_DATA) begin
          if ($urandom_range(0, 99) < 6) drive_noise(1'b0);
          drive_req(rand_req(nprs_pkg::OP_DATA), CHK_MODEL);
          real_items++;
        end
      end
    end
    steady = 1'b0;

    // Full page plus spare, left open after a few bytes
    r = rand_req(nprs_pkg::OP_READ);
    r.blk   = 12'($urandom_range(0, nprs_pkg::TOTAL_BLOCKS - 1));
    r.pg    = 7'($urandom_range(0, nprs_pkg::PAGES_PER_BLOCK - 1));
    r.col   = 12'd0;
    r.count = 12'(nprs_pkg::SPAN);
    drive_req(r, CHK_MODEL);
    r = rand_req(nprs_pkg::OP_READY);
    r.rdy = 1'b1;
    drive_req(r, CHK_MODEL);
    repeat (4) drive_req(rand_req(nprs_pkg::OP_DATA), CHK_MODEL);

    @(negedge clk);
    item_if.valid <= 1'b0;
    while (expected_bus_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Result side: random stalls, one long hold-off early in the random part
  initial begin : result_sink
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_off_done) begin
        result_if.ready <= 1'b0;
        for (int c = 1; c < HOLD_CYCLES; c++) @(negedge clk);
        hold_off_done = 1'b1;
      end else begin
        result_if.ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : check_results
    bus_result_t got;
    bus_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got = '{nprs_pkg::kind_t'(result_if.kind), result_if.value, result_if.last};
      if (expected_bus_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d value %02h last %0b",
                 $time, got.kind, got.value, got.last);
        errors++;
      end else begin
        want = expected_bus_results.pop_front();
        if (got !== want) begin
          $display("%0t: expected kind %0d value %02h last %0b, got kind %0d value %02h last %0b",
                   $time, want.kind, want.value, want.last, got.kind, got.value, got.last);
          errors++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
